// File: hdl/tbc_pkg.sv
package tbc_pkg;

    localparam int RUN_COUNTER_WIDTH = 24;
    localparam int THRESHOLD_WIDTH   = 24;
    localparam int LIMIT_WIDTH       = 8;
    localparam int CFG_INDEX_WIDTH   = 1;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QUEUE_AW          = 2;

    localparam logic [THRESHOLD_WIDTH-1:0] THRESHOLD_RESET = 24'd50000;
    localparam logic [LIMIT_WIDTH-1:0]     LIMIT_RESET     = 8'd150;
    localparam logic [3:0]                 LAST_BIT_INDEX  = 4'd7;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STROBE_HIGH_THRESHOLD = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ENTRY_LIMIT           = 1'd1;

    localparam logic [1:0] CLASS_LOW     = 2'd0;
    localparam logic [1:0] CLASS_RISING  = 2'd1;
    localparam logic [1:0] CLASS_FALLING = 2'd2;
    localparam logic [1:0] CLASS_HIGH    = 2'd3;

    // Results of one sample: an optional byte entry followed by an optional bit entry
    typedef struct packed {
        logic       has_byte;
        logic [7:0] byte_value;
        logic [7:0] byte_position;
        logic       halt;
        logic       has_bit;
        logic       bit_value;
        logic [7:0] bit_position;
    } job_t;

    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// File: hdl/tbc_if.sv
interface sample_if;
    logic valid;
    logic ready;
    logic strobe_level;
    logic clock_level;
    logic data_level;

    modport source (output valid, output strobe_level, output clock_level,
                    output data_level, input ready);
    modport sink (input valid, input strobe_level, input clock_level,
                  input data_level, output ready);
endinterface

interface entry_if;
    logic       valid;
    logic       ready;
    logic       entry_is_byte;
    logic [7:0] entry_value;
    logic [7:0] entry_position;
    logic       capture_ended;
    logic       last_of_run;

    modport source (output valid, output entry_is_byte, output entry_value,
                    output entry_position, output capture_ended, output last_of_run,
                    input ready);
    modport sink (input valid, input entry_is_byte, input entry_value,
                  input entry_position, input capture_ended, input last_of_run,
                  output ready);
endinterface

interface cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [23:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/three_wire_bus_capture.sv
// Three-wire bus capture.
// samples: one strobe/clock/data sample per transfer, taken every cycle while
//   the front queue has room. The front tracks the strobe class and run,
//   arms on a long strobe high ending in a falling edge, and turns each
//   rising clock edge into a bit entry, with a byte entry ahead of it once a
//   full byte is shifted in, until the entry limit halts capture.
// entries: one entry per transfer; a sample can yield zero, one or two.
//   last_of_run marks the final entry of its sample.
// cfg: register writes (0: strobe high threshold, 1: entry limit), always
//   accepted; write only while the block is idle.
// Path: an entry passes through the job queue and the output register.
// Throughput: one sample per cycle while the queue has room; the output
//   register's one-entry-per-cycle drain, when the receiver is ready, sets
//   the sustained rate; a two-entry job waits at the queue head for both.
// Stall: a stalled receiver holds the entry; the four-job queue keeps
//   taking samples until it fills, then samples.ready drops.
// Reset: all tracking and capture state clears, registers return to
//   50000 and 150, and capture stays disarmed until the next long strobe.
module three_wire_bus_capture #(
    parameter int RUN_COUNTER_WIDTH = tbc_pkg::RUN_COUNTER_WIDTH
) (
    input  logic    clk,
    input  logic    rst_n,
    sample_if.sink  samples,
    entry_if.source entries,
    cfg_if.sink     cfg
);

    tbc_pkg::job_t        push_job;
    tbc_pkg::job_t        head_job;
    tbc_pkg::queue_ctrl_t q_ctrl;
    tbc_pkg::queue_stat_t q_stat;
    logic                 push;
    logic                 pop;

    assign q_ctrl.push = push;
    assign q_ctrl.pop  = pop;

    tbc_front #(
        .RUN_W (RUN_COUNTER_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .cfg     (cfg),
        .q_stat  (q_stat),
        .push    (push),
        .job     (push_job)
    );

    tbc_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (q_ctrl),
        .wr_job (push_job),
        .head   (head_job),
        .stat   (q_stat)
    );

    tbc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head_job),
        .q_stat  (q_stat),
        .pop     (pop),
        .entries (entries)
    );

endmodule

// File: hdl/tbc_front.sv
module tbc_front #(
    parameter int RUN_W = tbc_pkg::RUN_COUNTER_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    sample_if.sink              samples,
    cfg_if.sink                 cfg,
    input  tbc_pkg::queue_stat_t q_stat,
    output logic                push,
    output tbc_pkg::job_t       job
);

    localparam int CMP_W = (RUN_W > tbc_pkg::THRESHOLD_WIDTH) ? RUN_W
                                                              : tbc_pkg::THRESHOLD_WIDTH;

    logic [tbc_pkg::THRESHOLD_WIDTH-1:0] threshold_reg;
    logic [tbc_pkg::LIMIT_WIDTH-1:0]     limit_reg;
    logic             strobe_last_reg, clock_last_reg;
    logic [1:0]       class_reg, class_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic             armed_reg, armed_next;
    logic [3:0]       bit_cnt_reg, bit_cnt_next;
    logic [7:0]       shift_reg, shift_next;
    logic [7:0]       entry_cnt_reg, entry_cnt_next;
    logic             halted_reg, halted_next;

    logic       accept;
    logic       fire;
    logic       byte_due;
    logic       halt;
    logic [7:0] cnt_after_byte;
    logic [3:0] bc0;
    logic [7:0] sb0;
    logic [8:0] cnt_plus_one;

    assign cfg.ready     = 1'b1;
    assign samples.ready = !q_stat.full;
    assign accept        = samples.valid && samples.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= tbc_pkg::THRESHOLD_RESET;
            limit_reg     <= tbc_pkg::LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == tbc_pkg::REG_STROBE_HIGH_THRESHOLD)
                threshold_reg <= cfg.data;
            else if (cfg.index == tbc_pkg::REG_ENTRY_LIMIT)
                limit_reg <= cfg.data[tbc_pkg::LIMIT_WIDTH-1:0];
        end
    end

    always_comb
    begin
        class_next = {strobe_last_reg, samples.strobe_level};
        if (class_next != class_reg)
            run_next = {{(RUN_W-1){1'b0}}, 1'b1};
        else if (!(&run_reg))
            run_next = run_reg + 1'b1;
        else
            run_next = run_reg;

        // arm on a falling strobe that ends a long enough run
        armed_next = armed_reg ||
                     ((CMP_W'(run_reg) > CMP_W'(threshold_reg)) &&
                      (class_next == tbc_pkg::CLASS_FALLING));

        fire         = armed_next && !halted_reg && !clock_last_reg && samples.clock_level;
        byte_due     = bit_cnt_reg > tbc_pkg::LAST_BIT_INDEX;
        cnt_plus_one = {1'b0, entry_cnt_reg} + 9'd1;
        halt         = cnt_plus_one > {1'b0, limit_reg};

        cnt_after_byte = entry_cnt_reg;
        bc0            = bit_cnt_reg;
        sb0            = shift_reg;
        halted_next    = halted_reg;
        bit_cnt_next   = bit_cnt_reg;
        shift_next     = shift_reg;
        entry_cnt_next = entry_cnt_reg;

        job.has_byte      = fire && byte_due;
        job.byte_value    = shift_reg;
        job.byte_position = entry_cnt_reg;
        job.halt          = halt;
        job.has_bit       = 1'b0;
        job.bit_value     = samples.data_level;
        job.bit_position  = entry_cnt_reg;

        if (fire)
        begin
            if (byte_due)
            begin
                cnt_after_byte = (&entry_cnt_reg) ? entry_cnt_reg : entry_cnt_reg + 8'd1;
                bc0            = 4'd0;
                sb0            = 8'd0;
            end
            if (byte_due && halt)
            begin
                // the halting byte stands alone: hold the shift state
                halted_next    = 1'b1;
                entry_cnt_next = cnt_after_byte;
            end
            else
            begin
                job.has_bit      = 1'b1;
                job.bit_position = cnt_after_byte;
                shift_next       = sb0 | (8'(samples.data_level) << bc0[2:0]);
                bit_cnt_next     = bc0 + 4'd1;
                entry_cnt_next   = (&cnt_after_byte) ? cnt_after_byte
                                                     : cnt_after_byte + 8'd1;
            end
        end
    end

    assign push = accept && fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_last_reg <= 1'b0;
            clock_last_reg  <= 1'b0;
            class_reg       <= tbc_pkg::CLASS_LOW;
            run_reg         <= '0;
            armed_reg       <= 1'b0;
            bit_cnt_reg     <= 4'd0;
            shift_reg       <= 8'd0;
            entry_cnt_reg   <= 8'd0;
            halted_reg      <= 1'b0;
        end
        else if (accept)
        begin
            strobe_last_reg <= samples.strobe_level;
            clock_last_reg  <= samples.clock_level;
            class_reg       <= class_next;
            run_reg         <= run_next;
            armed_reg       <= armed_next;
            bit_cnt_reg     <= bit_cnt_next;
            shift_reg       <= shift_next;
            entry_cnt_reg   <= entry_cnt_next;
            halted_reg      <= halted_next;
        end
    end

endmodule

// File: hdl/tbc_queue.sv
module tbc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tbc_pkg::queue_ctrl_t ctrl,
    input  tbc_pkg::job_t        wr_job,
    output tbc_pkg::job_t        head,
    output tbc_pkg::queue_stat_t stat
);

    tbc_pkg::job_t                 slot_reg [tbc_pkg::QUEUE_DEPTH];
    logic [tbc_pkg::QUEUE_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [tbc_pkg::QUEUE_AW:0]    count_reg, count_next;

    assign stat.full  = count_reg == (tbc_pkg::QUEUE_AW+1)'(tbc_pkg::QUEUE_DEPTH);
    assign stat.empty = count_reg == '0;
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push && !ctrl.pop)
            count_next = count_reg + 1'b1;
        else if (!ctrl.push && ctrl.pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (ctrl.push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (ctrl.pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// File: hdl/tbc_back.sv
module tbc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tbc_pkg::job_t        head,
    input  tbc_pkg::queue_stat_t q_stat,
    output logic                 pop,
    entry_if.source              entries
);

    logic       valid_reg;
    logic       phase_reg, phase_next;
    logic       load;
    logic       emit_byte;
    logic       is_byte_reg, is_byte_next;
    logic [7:0] value_reg, value_next;
    logic [7:0] pos_reg, pos_next;
    logic       ended_reg, ended_next;
    logic       last_reg, last_next;

    assign load      = !q_stat.empty && (!valid_reg || entries.ready);
    assign emit_byte = head.has_byte && !phase_reg;

    always_comb
    begin
        if (emit_byte)
        begin
            is_byte_next = 1'b1;
            value_next   = head.byte_value;
            pos_next     = head.byte_position;
            ended_next   = head.halt;
            last_next    = !head.has_bit;
        end
        else
        begin
            is_byte_next = 1'b0;
            value_next   = 8'(head.bit_value);
            pos_next     = head.bit_position;
            ended_next   = 1'b0;
            last_next    = 1'b1;
        end
        // stay on this job while its bit entry is still to go
        phase_next = emit_byte && head.has_bit;
        pop        = load && !phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                phase_reg <= phase_next;
            end
            else if (entries.ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            is_byte_reg <= is_byte_next;
            value_reg   <= value_next;
            pos_reg     <= pos_next;
            ended_reg   <= ended_next;
            last_reg    <= last_next;
        end
    end

    assign entries.valid          = valid_reg;
    assign entries.entry_is_byte  = is_byte_reg;
    assign entries.entry_value    = value_reg;
    assign entries.entry_position = pos_reg;
    assign entries.capture_ended  = ended_reg;
    assign entries.last_of_run    = last_reg;

endmodule
